### rtl/core/sfc_pkg.sv
// Shared types, constants and the CRC-8 byte update of the sensor frame checker.
// No dependencies; used by every module in rtl/core.
`default_nettype none

package sfc_pkg;

	// frame layout: each word is high byte, low byte, CRC byte
	localparam int unsigned WordsPerFrame = 3;
	localparam int unsigned BytesPerWord  = 3;

	localparam logic [7:0]  CrcPoly = 8'h31;
	localparam logic [7:0]  CrcInit = 8'hFF;
	localparam logic [13:0] HumiMax = 14'd9999;

	// register indexes of the configuration port
	localparam logic [7:0] RegTempGain   = 8'd0;
	localparam logic [7:0] RegTempOffset = 8'd1;
	localparam logic [7:0] RegHumiGain   = 8'd2;
	localparam logic [7:0] RegHumiOffset = 8'd3;

	// register values after reset
	localparam logic signed [15:0] TempGainRst   = 16'sd17500;
	localparam logic signed [15:0] TempOffsetRst = -16'sd4500;
	localparam logic [14:0]        HumiGainRst   = 15'd10000;
	localparam logic signed [15:0] HumiOffsetRst = 16'sd0;

	// byte phase inside a word
	typedef enum logic [1:0] {
		PH_HIGH = 2'd0,
		PH_LOW  = 2'd1,
		PH_CRC  = 2'd2
	} sfc_phase_t;

	typedef struct packed {
		logic signed [15:0] temp_gain;
		logic signed [15:0] temp_offset;
		logic [14:0]        humi_gain;
		logic signed [15:0] humi_offset;
	} sfc_cfg_t;

	// one completed frame, ready for scaling
	typedef struct packed {
		logic [15:0] co2;
		logic [15:0] temp_raw;
		logic [15:0] humi_raw;
		logic        bad;
		logic [15:0] count;
	} sfc_sample_t;

	// shift one byte through the CRC register, MSB first, no reflection
	function automatic logic [7:0] crc8_shift(input logic [7:0] c_in);
		logic [7:0] c;
		c = c_in;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### rtl/core/sfc_frame_parser.sv
// Byte framing, per-word CRC-8 check and good-frame counter.
// Depends on sfc_pkg; feeds each completed frame into sfc_scaler.
`default_nettype none

module sfc_frame_parser
	import sfc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic        load_ok,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        frame_start,
	output logic             valid_s1,
	output sfc_sample_t      sample_s1
);

	sfc_phase_t  phase_q;
	logic [1:0]  word_q;
	logic [7:0]  high_q;
	logic [7:0]  crc_q;
	logic [15:0] co2_q;
	logic [15:0] temp_q;
	logic [15:0] humi_q;
	logic        bad_q;
	logic [15:0] count_q;

	sfc_phase_t  phase_eff;
	logic [1:0]  word_eff;
	logic        bad_eff;
	logic        bad_next;
	logic        last_byte;
	logic [15:0] word_val;
	logic [15:0] count_next;

	// a frame mark restarts the frame and drops any partial one
	always_comb begin
		phase_eff  = frame_start ? PH_HIGH : phase_q;
		word_eff   = frame_start ? 2'd0 : word_q;
		bad_eff    = (frame_start || (phase_eff == PH_HIGH && word_eff == 2'd0)) ? 1'b0
			: bad_q;
		bad_next   = bad_eff || (rx_byte != crc_q);
		last_byte  = (phase_eff == PH_CRC) &&
			(word_eff == 2'(WordsPerFrame - 1));
		word_val   = {high_q, rx_byte};
		count_next = bad_next ? count_q : count_q + 16'd1;
	end

	// advance framing state on each byte transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HIGH;
			word_q  <= 2'd0;
			high_q  <= 8'd0;
			crc_q   <= CrcInit;
			co2_q   <= 16'd0;
			temp_q  <= 16'd0;
			humi_q  <= 16'd0;
			bad_q   <= 1'b0;
			count_q <= 16'd0;
		end else if (accept) begin
			case (phase_eff)
				PH_HIGH: begin
					high_q  <= rx_byte;
					crc_q   <= crc8_shift(CrcInit ^ rx_byte);
					bad_q   <= bad_eff;
					phase_q <= PH_LOW;
					word_q  <= word_eff;
				end
				PH_LOW: begin
					crc_q   <= crc8_shift(crc_q ^ rx_byte);
					bad_q   <= bad_eff;
					phase_q <= PH_CRC;
					word_q  <= word_eff;
					case (word_eff)
						2'd0:    co2_q  <= word_val;
						2'd1:    temp_q <= word_val;
						default: humi_q <= word_val;
					endcase
				end
				default: begin
					phase_q <= PH_HIGH;
					if (last_byte) begin
						word_q  <= 2'd0;
						bad_q   <= 1'b0;
						count_q <= count_next;
					end else begin
						word_q <= word_eff + 2'd1;
						bad_q  <= bad_next;
					end
				end
			endcase
		end
	end

	// hold the completed frame until the scaler takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_ok) begin
			valid_s1 <= accept && last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok && accept && last_byte) begin
			sample_s1.co2      <= co2_q;
			sample_s1.temp_raw <= temp_q;
			sample_s1.humi_raw <= humi_q;
			sample_s1.bad      <= bad_next;
			sample_s1.count    <= count_next;
		end
	end

endmodule

`default_nettype wire

### rtl/core/sfc_scaler.sv
// Two-stage scaling pipeline: multiply stage, then offset, wrap, clamp into the
// output register. Depends on sfc_pkg.
`default_nettype none

module sfc_scaler
	import sfc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire sfc_cfg_t     cfg,
	input  wire logic         valid_s1,
	input  wire sfc_sample_t  sample_s1,
	output logic              take_s1,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [15:0]       co2_ppm,
	output logic signed [15:0] temperature,
	output logic [13:0]       humidity,
	output logic              crc_error,
	output logic [15:0]       sample_count
);

	logic                valid_s2;
	logic signed [32:0]  temp_prod_s2;
	logic [30:0]         humi_prod_s2;
	logic [15:0]         co2_s2;
	logic                bad_s2;
	logic [15:0]         count_s2;

	logic                load_out;
	logic                take_s2;
	logic signed [15:0]  temp_sum;
	logic [16:0]         humi_sum;
	logic [15:0]         humi_wrap;
	logic [13:0]         humi_clamp;

	assign load_out = !out_valid || !out_stall;
	assign take_s2  = load_out;
	assign take_s1  = !valid_s2 || take_s2;

	// multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && valid_s1) begin
			temp_prod_s2 <= $signed({1'b0, sample_s1.temp_raw}) * cfg.temp_gain;
			humi_prod_s2 <= sample_s1.humi_raw * cfg.humi_gain;
			co2_s2       <= sample_s1.co2;
			bad_s2       <= sample_s1.bad;
			count_s2     <= sample_s1.count;
		end
	end

	// floor shift, add offset, wrap to 16 bits, clamp humidity
	always_comb begin
		temp_sum  = temp_prod_s2[31:16] + cfg.temp_offset;
		humi_sum  = {2'b00, humi_prod_s2[30:16]} +
			{cfg.humi_offset[15], cfg.humi_offset};
		humi_wrap = humi_sum[15:0];
		if (humi_wrap[15]) begin
			humi_clamp = 14'd0;
		end else if (humi_wrap > {2'b00, HumiMax}) begin
			humi_clamp = HumiMax;
		end else begin
			humi_clamp = humi_wrap[13:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out && valid_s2) begin
			co2_ppm      <= bad_s2 ? 16'd0 : co2_s2;
			temperature  <= bad_s2 ? 16'sd0 : temp_sum;
			humidity     <= bad_s2 ? 14'd0 : humi_clamp;
			crc_error    <= bad_s2;
			sample_count <= count_s2;
		end
	end

endmodule

`default_nettype wire

### rtl/core/sensor_frame_crc_check_and_scale.sv
// Top level of the sensor frame checker: configuration registers, parser and
// scaler. Depends on sfc_pkg, sfc_frame_parser and sfc_scaler.
//
// Usage:
//   Input channel (in_valid / in_stall): one received byte per transfer, with
//   frame_start marking the first byte of a nine-byte frame. Without the
//   mark, frames follow one another back to back.
//   Output channel (out_valid / out_stall): one result per frame, on the
//   ninth byte: CO2, scaled temperature and clamped humidity, or crc_error
//   with zeroed values. sample_count counts good frames and wraps.
//   Config channel (cfg_valid / cfg_ready): always ready; write only while
//   no frame result is outstanding.
//   Throughput: one byte per cycle while in_stall is low. The result of a
//   frame passes through the frame register, which loads on the transfer of
//   its ninth byte, then the multiply stage and the output register.
//   Stalling: a waiting result sits in the output register while the
//   multiply stage behind it can still take one frame; in_stall rises once
//   the multiply stage and the output register both hold a frame and
//   out_stall is high, whether or not the frame register holds one.
//   Reset: arst_n clears the framing state, the counter and the pipeline and
//   loads the default gains and offsets.
`default_nettype none

module sensor_frame_crc_check_and_scale
	import sfc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [7:0]   rx_byte,
	input  wire logic         frame_start,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [15:0]       co2_ppm,
	output logic signed [15:0] temperature,
	output logic [13:0]       humidity,
	output logic              crc_error,
	output logic [15:0]       sample_count,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [7:0]   cfg_index,
	input  wire logic [15:0]  cfg_data
);

	sfc_cfg_t    cfg_q;
	logic        valid_s1;
	sfc_sample_t sample_s1;
	logic        take_s1;
	logic        accept;

	assign cfg_ready = 1'b1;
	assign in_stall  = !take_s1;
	assign accept    = in_valid && !in_stall;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_gain   <= TempGainRst;
			cfg_q.temp_offset <= TempOffsetRst;
			cfg_q.humi_gain   <= HumiGainRst;
			cfg_q.humi_offset <= HumiOffsetRst;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				RegTempGain:   cfg_q.temp_gain   <= cfg_data;
				RegTempOffset: cfg_q.temp_offset <= cfg_data;
				RegHumiGain:   cfg_q.humi_gain   <= cfg_data[14:0];
				RegHumiOffset: cfg_q.humi_offset <= cfg_data;
				default: ;
			endcase
		end
	end

	sfc_frame_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.load_ok     (take_s1),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.valid_s1    (valid_s1),
		.sample_s1   (sample_s1)
	);

	sfc_scaler u_scaler (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.valid_s1     (valid_s1),
		.sample_s1    (sample_s1),
		.take_s1      (take_s1),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.co2_ppm      (co2_ppm),
		.temperature  (temperature),
		.humidity     (humidity),
		.crc_error    (crc_error),
		.sample_count (sample_count)
	);

	// input held back only while the sink stalls a waiting result
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled with no waiting result");

	// failed frames carry no measurement
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && crc_error) |->
			(co2_ppm == 16'd0 && temperature == 16'sd0 && humidity == 14'd0))
		else $error("failed frame carries measurement data");

	// humidity stays inside its clamp range
	a_humi_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (humidity <= HumiMax))
		else $error("humidity above clamp limit");

endmodule

`default_nettype wire
